// ----- rtl/esc_pkg.sv -----
package esc_pkg;

    localparam int POS_W = 16;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SWITCH = 2'd1,
        KIND_KEY    = 2'd2
    } t_kind;

    typedef struct packed {
        logic move;
        logic up;
    } t_lane_step;

endpackage

// ----- rtl/esc_lane.sv -----
module esc_lane
    import esc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_a,
    input  logic       i_b,
    output t_lane_step o_step
);

    logic [1:0] r_phase;
    logic       r_dir;
    logic [1:0] n_code;
    logic [1:0] n_diff;

    assign n_code = {i_b, i_a ^ i_b};
    assign n_diff = n_code - r_phase;

    always_comb begin
        o_step.move = (n_diff != 2'd0);
        o_step.up   = (n_diff == 2'd1) || ((n_diff == 2'd2) && !r_dir);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_dir   <= 1'b0;
        end else if (i_en && o_step.move) begin
            r_phase <= n_code;
            if (n_diff == 2'd1) begin
                r_dir <= 1'b0;
            end else if (n_diff == 2'd3) begin
                r_dir <= 1'b1;
            end
        end
    end

endmodule

// ----- rtl/esc_merge.sv -----
module esc_merge
    import esc_pkg::*;
#(
    parameter int NUM_ENCODERS = 3,
    parameter int NUM_KEYS     = 20,
    parameter int VALUE_W      = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [NUM_ENCODERS-1:0]       i_switch,
    input  logic [NUM_KEYS-1:0]           i_keys,
    input  t_lane_step [NUM_ENCODERS-1:0] i_steps,
    output t_kind                         o_kind,
    output logic [VALUE_W-1:0]            o_value,
    output logic [POS_W-1:0]              o_pos
);

    localparam int DELTA_W = $clog2(NUM_ENCODERS + 1) + 1;

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [DELTA_W-1:0] n_delta;
    logic               n_sw_hit;

    always_comb begin
        n_delta = '0;
        for (int k = 0; k < NUM_ENCODERS; k++) begin
            if (i_steps[k].move) begin
                n_delta = i_steps[k].up ? n_delta + DELTA_W'(1) : n_delta - DELTA_W'(1);
            end
        end
    end

    assign n_sw_hit = |i_switch;
    assign n_pos    = n_sw_hit ? r_pos
                    : r_pos + {{(POS_W-DELTA_W){n_delta[DELTA_W-1]}}, n_delta};
    assign o_pos    = n_pos;

    always_comb begin
        o_kind  = KIND_NONE;
        o_value = '0;
        if (n_sw_hit) begin
            o_kind = KIND_SWITCH;
            for (int k = NUM_ENCODERS - 1; k >= 0; k--) begin
                if (i_switch[k]) begin
                    o_value = VALUE_W'(k);
                end
            end
        end else if (|i_keys) begin
            o_kind = KIND_KEY;
            for (int k = NUM_KEYS - 1; k >= 0; k--) begin
                if (i_keys[k]) begin
                    o_value = VALUE_W'(k);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_en) begin
            r_pos <= n_pos;
        end
    end

endmodule

// ----- rtl/encoder_and_keypad_input_scanner_core.sv -----
// Encoder and keypad scanner core.
// Input channel: one beat per pin sample (i_in_valid / o_in_stall) carrying the
// encoder push switch levels, encoder phase A and B levels and the key matrix
// bits, key number row*KEY_COLS+col.
// Output channel: one beat per input beat (o_out_valid / i_out_stall) carrying
// the action kind (none, encoder switch, matrix key), the encoder index or key
// number, and the shared 16-bit position count after that sample.
// A pressed encoder switch wins over everything and leaves the encoders and
// the count untouched; otherwise each encoder lane moves the count by one step.
// Each accepted beat is registered and shows on the output the next cycle.
// Throughput is one beat per cycle unless the receiver stalls: the lanes and
// merge feed a single output register, and a new beat is taken in the same
// cycle the held result is drained. While the receiver stalls with a result
// held, o_in_stall is high and the result stays put. Synchronous active-low
// reset clears phases, directions and count to zero and empties the output register.
module encoder_and_keypad_input_scanner_core
    import esc_pkg::*;
#(
    parameter int NUM_ENCODERS = 3,
    parameter int KEY_ROWS     = 5,
    parameter int KEY_COLS     = 4,
    localparam int NUM_KEYS    = KEY_ROWS * KEY_COLS,
    localparam int VALUE_N     = (NUM_KEYS > NUM_ENCODERS) ? NUM_KEYS : NUM_ENCODERS,
    localparam int VALUE_W     = (VALUE_N > 2) ? $clog2(VALUE_N) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [NUM_ENCODERS-1:0]             i_enc_switch_levels,
    input  logic [NUM_ENCODERS-1:0]             i_enc_a_levels,
    input  logic [NUM_ENCODERS-1:0]             i_enc_b_levels,
    input  logic [KEY_ROWS*KEY_COLS-1:0]        i_key_pressed,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_action_kind,
    output logic [VALUE_W-1:0]                  o_action_value,
    output logic signed [POS_W-1:0]             o_position_count
);

    t_lane_step [NUM_ENCODERS-1:0] w_steps;
    t_kind                         w_kind;
    logic [VALUE_W-1:0]            w_value;
    logic [POS_W-1:0]              w_pos;
    logic                          w_accept;
    logic                          w_lane_en;

    logic                          r_out_valid;
    t_kind                         r_kind;
    logic [VALUE_W-1:0]            r_value;
    logic [POS_W-1:0]              r_pos;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_lane_en  = w_accept && (i_enc_switch_levels == '0);

    for (genvar g = 0; g < NUM_ENCODERS; g++) begin : g_lane
        esc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_lane_en),
            .i_a     (i_enc_a_levels[g]),
            .i_b     (i_enc_b_levels[g]),
            .o_step  (w_steps[g])
        );
    end

    esc_merge #(
        .NUM_ENCODERS (NUM_ENCODERS),
        .NUM_KEYS     (NUM_KEYS),
        .VALUE_W      (VALUE_W)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_accept),
        .i_switch (i_enc_switch_levels),
        .i_keys   (i_key_pressed),
        .i_steps  (w_steps),
        .o_kind   (w_kind),
        .o_value  (w_value),
        .o_pos    (w_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= w_kind;
            r_value <= w_value;
            r_pos   <= w_pos;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action_kind    = r_kind;
    assign o_action_value   = r_value;
    assign o_position_count = r_pos;

`ifndef NO_ASSERTIONS
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted beat did not reach the output register");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output register");

    a_switch_wins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_enc_switch_levels != '0)) |=> (r_kind == KIND_SWITCH))
        else $error("pressed encoder switch not reported");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_NONE)) |-> (r_value == '0))
        else $error("empty action carries a nonzero value");
`endif

endmodule
